>>> hdl/cdad_pkg.sv
// shared types, constants, calendar helpers and microcode rom for the date adder
`timescale 1ns / 1ps

package cdad_pkg;

  localparam int YEAR_BITS_DEF   = 16;
  localparam int OFFSET_BITS_DEF = 21;

  localparam int YEAR_W   = 16;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int OFFSET_W = 21;

  localparam int CYCLE_DAYS  = 146097;
  localparam int CYCLE_YEARS = 400;
  localparam int CENTURY     = 100;
  localparam int MONTHS      = 12;
  localparam int FEB         = 2;
  localparam int FEB_LEAP    = 29;
  localparam int FEB_PLAIN   = 28;

  // year modulo 400 fits in 9 bits
  localparam int RES_W = 9;
  typedef logic [RES_W-1:0] res_t;

  localparam logic [DAY_W-1:0] MONTH_LEN [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MOD,
    OP_CYC_FWD,
    OP_CYC_BACK,
    OP_FWD_STEP,
    OP_YEAR_INC,
    OP_BACK_STEP,
    OP_YEAR_DEC,
    OP_LOAD_DIM,
    OP_BACK_FIN,
    OP_OUT_OK,
    OP_OUT_BAD,
    OP_OUT_RANGE
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_CNT_MORE,
    C_BAD_DATE,
    C_NEG,
    C_REM_LT_CYC,
    C_FWD_OVF,
    C_REM_ZERO,
    C_MONTH_OK,
    C_YEAR_MAX,
    C_BACK_UNF,
    C_DAY_GT_REM,
    C_MONTH_NZ,
    C_YEAR_MIN,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic cnt_more;
    logic bad_date;
    logic neg;
    logic rem_lt_cyc;
    logic fwd_ovf;
    logic rem_zero;
    logic month_ok;
    logic year_max;
    logic back_unf;
    logic day_gt_rem;
    logic month_nz;
    logic year_min;
    logic out_busy;
  } flags_t;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
    logic  last;
  } uword_t;

  localparam upc_t U_IDLE      = 5'd0;
  localparam upc_t U_MOD       = 5'd1;
  localparam upc_t U_CHECK     = 5'd2;
  localparam upc_t U_DIR       = 5'd3;
  localparam upc_t U_FWD_CYC   = 5'd4;
  localparam upc_t U_FWD_OVF   = 5'd5;
  localparam upc_t U_FWD_ADD   = 5'd6;
  localparam upc_t U_FWD_MON   = 5'd7;
  localparam upc_t U_FWD_STEP  = 5'd8;
  localparam upc_t U_FWD_WRAP  = 5'd9;
  localparam upc_t U_FWD_YMAX  = 5'd10;
  localparam upc_t U_FWD_YINC  = 5'd11;
  localparam upc_t U_BACK_CYC  = 5'd12;
  localparam upc_t U_BACK_UNF  = 5'd13;
  localparam upc_t U_BACK_SUB  = 5'd14;
  localparam upc_t U_BACK_MON  = 5'd15;
  localparam upc_t U_BACK_TEST = 5'd16;
  localparam upc_t U_BACK_STEP = 5'd17;
  localparam upc_t U_BACK_WRAP = 5'd18;
  localparam upc_t U_BACK_YMIN = 5'd19;
  localparam upc_t U_BACK_YDEC = 5'd20;
  localparam upc_t U_BACK_DIM  = 5'd21;
  localparam upc_t U_BACK_FIN  = 5'd22;
  localparam upc_t U_DONE      = 5'd23;
  localparam upc_t U_ERR_BAD   = 5'd24;
  localparam upc_t U_ERR_RANGE = 5'd25;

  function automatic uword_t ucode(upc_t a);
    uword_t w;
    w = '{OP_NOP, C_ALWAYS, U_IDLE, 1'b0};
    case (a)
      U_IDLE:      w = '{OP_LOAD,      C_NO_REQ,     U_IDLE,      1'b0};
      U_MOD:       w = '{OP_MOD,       C_CNT_MORE,   U_MOD,       1'b0};
      U_CHECK:     w = '{OP_NOP,       C_BAD_DATE,   U_ERR_BAD,   1'b0};
      U_DIR:       w = '{OP_NOP,       C_NEG,        U_BACK_CYC,  1'b0};
      U_FWD_CYC:   w = '{OP_NOP,       C_REM_LT_CYC, U_FWD_MON,   1'b0};
      U_FWD_OVF:   w = '{OP_NOP,       C_FWD_OVF,    U_ERR_RANGE, 1'b0};
      U_FWD_ADD:   w = '{OP_CYC_FWD,   C_ALWAYS,     U_FWD_CYC,   1'b0};
      U_FWD_MON:   w = '{OP_NOP,       C_REM_ZERO,   U_DONE,      1'b0};
      U_FWD_STEP:  w = '{OP_FWD_STEP,  C_NEVER,      U_IDLE,      1'b0};
      U_FWD_WRAP:  w = '{OP_NOP,       C_MONTH_OK,   U_FWD_MON,   1'b0};
      U_FWD_YMAX:  w = '{OP_NOP,       C_YEAR_MAX,   U_ERR_RANGE, 1'b0};
      U_FWD_YINC:  w = '{OP_YEAR_INC,  C_ALWAYS,     U_FWD_MON,   1'b0};
      U_BACK_CYC:  w = '{OP_NOP,       C_REM_LT_CYC, U_BACK_MON,  1'b0};
      U_BACK_UNF:  w = '{OP_NOP,       C_BACK_UNF,   U_ERR_RANGE, 1'b0};
      U_BACK_SUB:  w = '{OP_CYC_BACK,  C_ALWAYS,     U_BACK_CYC,  1'b0};
      U_BACK_MON:  w = '{OP_NOP,       C_REM_ZERO,   U_DONE,      1'b0};
      U_BACK_TEST: w = '{OP_NOP,       C_DAY_GT_REM, U_BACK_FIN,  1'b0};
      U_BACK_STEP: w = '{OP_BACK_STEP, C_NEVER,      U_IDLE,      1'b0};
      U_BACK_WRAP: w = '{OP_NOP,       C_MONTH_NZ,   U_BACK_DIM,  1'b0};
      U_BACK_YMIN: w = '{OP_NOP,       C_YEAR_MIN,   U_ERR_RANGE, 1'b0};
      U_BACK_YDEC: w = '{OP_YEAR_DEC,  C_NEVER,      U_IDLE,      1'b0};
      U_BACK_DIM:  w = '{OP_LOAD_DIM,  C_ALWAYS,     U_BACK_MON,  1'b0};
      U_BACK_FIN:  w = '{OP_BACK_FIN,  C_ALWAYS,     U_DONE,      1'b0};
      U_DONE:      w = '{OP_OUT_OK,    C_OUT_BUSY,   U_DONE,      1'b1};
      U_ERR_BAD:   w = '{OP_OUT_BAD,   C_OUT_BUSY,   U_ERR_BAD,   1'b1};
      U_ERR_RANGE: w = '{OP_OUT_RANGE, C_OUT_BUSY,   U_ERR_RANGE, 1'b1};
      default:     w = '{OP_NOP,       C_ALWAYS,     U_IDLE,      1'b0};
    endcase
    return w;
  endfunction

  // month length from the year's residue modulo 400
  function automatic logic [DAY_W-1:0] days_in(res_t r, logic [MONTH_W-1:0] m);
    logic leap;
    logic [DAY_W-1:0] len;
    leap = (r[1:0] == 2'b00 && r != RES_W'(CENTURY) && r != RES_W'(2 * CENTURY) &&
            r != RES_W'(3 * CENTURY)) || r == '0;
    if (m == MONTH_W'(FEB)) begin
      len = leap ? DAY_W'(FEB_LEAP) : DAY_W'(FEB_PLAIN);
    end else if (m <= MONTH_W'(MONTHS)) begin
      len = MONTH_LEN[m];
    end else begin
      len = '0;
    end
    return len;
  endfunction

endpackage

>>> hdl/cdad_seq.sv
// microcode sequencer: step counter, control rom and jump condition select
`timescale 1ns / 1ps

module cdad_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  cdad_pkg::flags_t flags,
  output logic            in_ready,
  output cdad_pkg::op_t   op
);
  import cdad_pkg::*;

  upc_t   upc_r;
  upc_t   upc_nxt;
  uword_t uw;
  logic   take;

  assign uw       = ucode(upc_r);
  assign in_ready = (upc_r == U_IDLE);

  always_comb begin
    case (uw.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_REQ:     take = !in_valid;
      C_CNT_MORE:   take = flags.cnt_more;
      C_BAD_DATE:   take = flags.bad_date;
      C_NEG:        take = flags.neg;
      C_REM_LT_CYC: take = flags.rem_lt_cyc;
      C_FWD_OVF:    take = flags.fwd_ovf;
      C_REM_ZERO:   take = flags.rem_zero;
      C_MONTH_OK:   take = flags.month_ok;
      C_YEAR_MAX:   take = flags.year_max;
      C_BACK_UNF:   take = flags.back_unf;
      C_DAY_GT_REM: take = flags.day_gt_rem;
      C_MONTH_NZ:   take = flags.month_nz;
      C_YEAR_MIN:   take = flags.year_min;
      C_OUT_BUSY:   take = flags.out_busy;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      upc_nxt = uw.target;
    end else if (uw.last) begin
      upc_nxt = U_IDLE;
    end else begin
      upc_nxt = upc_r + upc_t'(1);
    end
  end

  // hold off the load without a request and the result write while the output is full
  always_comb begin
    op = uw.op;
    if (uw.op == OP_LOAD && !in_valid) begin
      op = OP_NOP;
    end
    if ((uw.op == OP_OUT_OK || uw.op == OP_OUT_BAD || uw.op == OP_OUT_RANGE) &&
        flags.out_busy) begin
      op = OP_NOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

>>> hdl/cdad_dp.sv
// date datapath: year, month, day and remaining-day registers, flags and result register
`timescale 1ns / 1ps

module cdad_dp #(
  parameter int YEAR_BITS   = cdad_pkg::YEAR_BITS_DEF,
  parameter int OFFSET_BITS = cdad_pkg::OFFSET_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cdad_pkg::op_t                    op,
  input  logic [cdad_pkg::YEAR_W-1:0]      in_start_year,
  input  logic [cdad_pkg::MONTH_W-1:0]     in_start_month,
  input  logic [cdad_pkg::DAY_W-1:0]       in_start_day,
  input  logic signed [cdad_pkg::OFFSET_W-1:0] in_day_offset,
  input  logic                             out_ready,
  output cdad_pkg::flags_t                 flags,
  output logic                             out_valid,
  output logic [cdad_pkg::YEAR_W-1:0]      out_result_year,
  output logic [cdad_pkg::MONTH_W-1:0]     out_result_month,
  output logic [cdad_pkg::DAY_W-1:0]       out_result_day,
  output logic [1:0]                       out_status
);
  import cdad_pkg::*;

  localparam int YW    = YEAR_BITS;
  localparam int RW    = OFFSET_BITS;
  localparam int CNT_W = 2;
  localparam int MOD_STEPS = 2;
  localparam int CMP_W = (OFFSET_BITS > 18) ? OFFSET_BITS : 18;
  localparam logic [YW-1:0] YMAX     = '1;
  localparam logic [YW-1:0] YFWD_LIM = YMAX - YW'(CYCLE_YEARS);

  // year modulo 400 as 16 * ((year / 16) modulo 25) + year modulo 16
  localparam int LOW_W   = 4;
  localparam int RES_DIV = CYCLE_YEARS / (1 << LOW_W);
  localparam int HI_W    = YEAR_BITS - LOW_W;
  localparam int QSH     = HI_W + 5;
  localparam int MAG_W   = HI_W + 1;
  localparam longint unsigned MAG =
    ((64'd1 << QSH) + 64'(RES_DIV - 1)) / 64'(RES_DIV);
  localparam logic [MAG_W-1:0] MAGIC = MAG_W'(MAG);

  logic [YW-1:0]      y_r;
  logic [HI_W-1:0]    q_r;
  logic [MONTH_W-1:0] m_r;
  logic [DAY_W-1:0]   d_r;
  logic [RW-1:0]      rem_r;
  logic               neg_r;
  logic [CNT_W-1:0]   cnt_r;
  res_t               res_r;

  logic               out_valid_r;
  logic [YEAR_W-1:0]  year_out_r;
  logic [MONTH_W-1:0] month_out_r;
  logic [DAY_W-1:0]   day_out_r;
  status_t            status_out_r;

  logic [31:0]        in_y_ext;
  logic [31:0]        in_off_ext;
  logic [31:0]        y_ext;
  logic [RW-1:0]      oraw;
  logic [DAY_W-1:0]   dim;
  logic [DAY_W:0]     left;
  logic               rem_lt_left;
  logic [HI_W-1:0]    yhi;
  logic [HI_W+MAG_W-1:0] prod;
  logic [HI_W-1:0]    hi_rem;

  assign in_y_ext   = {{(32 - YEAR_W){1'b0}}, in_start_year};
  assign in_off_ext = {{(32 - OFFSET_W){1'b0}}, in_day_offset};
  assign oraw       = in_off_ext[RW-1:0];
  assign y_ext      = 32'(y_r);

  assign yhi    = y_r[YW-1:LOW_W];
  assign prod   = (HI_W + MAG_W)'(yhi) * (HI_W + MAG_W)'(MAGIC);
  assign hi_rem = yhi - q_r * HI_W'(RES_DIV);

  assign dim         = days_in(res_r, m_r);
  assign left        = {1'b0, dim} - {1'b0, d_r} + (DAY_W + 1)'(1);
  assign rem_lt_left = rem_r < RW'(left);

  assign flags.cnt_more   = cnt_r != CNT_W'(1);
  assign flags.bad_date   = y_r == '0 || m_r == '0 || m_r > MONTH_W'(MONTHS) ||
                            d_r == '0 || d_r > dim;
  assign flags.neg        = neg_r;
  assign flags.rem_lt_cyc = CMP_W'(rem_r) < CMP_W'(CYCLE_DAYS);
  assign flags.fwd_ovf    = y_r > YFWD_LIM;
  assign flags.rem_zero   = rem_r == '0;
  assign flags.month_ok   = m_r <= MONTH_W'(MONTHS);
  assign flags.year_max   = y_r == YMAX;
  assign flags.back_unf   = y_r <= YW'(CYCLE_YEARS);
  assign flags.day_gt_rem = RW'(d_r) > rem_r;
  assign flags.month_nz   = m_r != '0;
  assign flags.year_min   = y_r <= YW'(1);
  assign flags.out_busy   = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        y_r   <= in_y_ext[YW-1:0];
        m_r   <= in_start_month;
        d_r   <= in_start_day;
        neg_r <= oraw[RW-1];
        rem_r <= oraw[RW-1] ? (~oraw + RW'(1)) : oraw;
        cnt_r <= CNT_W'(MOD_STEPS);
        res_r <= '0;
      end
      OP_MOD: begin
        // first step forms the quotient, second step the residue
        cnt_r <= cnt_r - CNT_W'(1);
        q_r   <= HI_W'(prod >> QSH);
        res_r <= {hi_rem[RES_W-LOW_W-1:0], y_r[LOW_W-1:0]};
      end
      OP_CYC_FWD: begin
        y_r   <= y_r + YW'(CYCLE_YEARS);
        rem_r <= rem_r - RW'(CYCLE_DAYS);
      end
      OP_CYC_BACK: begin
        y_r   <= y_r - YW'(CYCLE_YEARS);
        rem_r <= rem_r - RW'(CYCLE_DAYS);
      end
      OP_FWD_STEP: begin
        if (rem_lt_left) begin
          d_r   <= d_r + rem_r[DAY_W-1:0];
          rem_r <= '0;
        end else begin
          rem_r <= rem_r - RW'(left);
          d_r   <= DAY_W'(1);
          m_r   <= m_r + MONTH_W'(1);
        end
      end
      OP_YEAR_INC: begin
        y_r   <= y_r + YW'(1);
        m_r   <= MONTH_W'(1);
        res_r <= (res_r == RES_W'(CYCLE_YEARS - 1)) ? '0 : res_r + RES_W'(1);
      end
      OP_BACK_STEP: begin
        rem_r <= rem_r - RW'(d_r);
        m_r   <= m_r - MONTH_W'(1);
      end
      OP_YEAR_DEC: begin
        y_r   <= y_r - YW'(1);
        m_r   <= MONTH_W'(MONTHS);
        res_r <= (res_r == '0) ? RES_W'(CYCLE_YEARS - 1) : res_r - RES_W'(1);
      end
      OP_LOAD_DIM: begin
        d_r <= dim;
      end
      OP_BACK_FIN: begin
        d_r   <= d_r - rem_r[DAY_W-1:0];
        rem_r <= '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_OUT_OK: begin
        year_out_r   <= y_ext[YEAR_W-1:0];
        month_out_r  <= m_r;
        day_out_r    <= d_r;
        status_out_r <= ST_OK;
      end
      OP_OUT_BAD: begin
        year_out_r   <= '0;
        month_out_r  <= '0;
        day_out_r    <= '0;
        status_out_r <= ST_BAD_DATE;
      end
      OP_OUT_RANGE: begin
        year_out_r   <= '0;
        month_out_r  <= '0;
        day_out_r    <= '0;
        status_out_r <= ST_RANGE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == OP_OUT_OK || op == OP_OUT_BAD || op == OP_OUT_RANGE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_year  = year_out_r;
  assign out_result_month = month_out_r;
  assign out_result_day   = day_out_r;
  assign out_status       = status_out_r;

endmodule

>>> hdl/calendar_date_add_days.sv
// top level of the gregorian date adder: sequencer plus datapath
// Usage:
// A request on the in_ channel carries a start date (year, month, day) and a signed
// day offset; the out_ channel returns one result per request: the moved date and a
// status (ok, invalid start date, year out of range; the date is zero on error).
// in_ready is high only while the sequencer sits at its idle step, so one request is
// worked on at a time; a finished result waits in the output register, and the next
// request is taken as soon as the result has been written there.
// Steps: the year is reduced modulo 400 in two steps and the date is checked,
// then each whole 400-year block of the offset is stepped over, then the months
// are walked forward or backward, with extra steps at each year boundary, and
// the result is written. Every step runs through the one datapath under the
// microcode rom.
// Reset clears the step counter and the output valid flag; the block then idles.
// If the receiver holds out_ready low, the result register holds its content and
// the sequencer waits at its final step until the register can be written.
`timescale 1ns / 1ps

module calendar_date_add_days #(
  parameter int YEAR_BITS   = cdad_pkg::YEAR_BITS_DEF,
  parameter int OFFSET_BITS = cdad_pkg::OFFSET_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [cdad_pkg::YEAR_W-1:0]          in_start_year,
  input  logic [cdad_pkg::MONTH_W-1:0]         in_start_month,
  input  logic [cdad_pkg::DAY_W-1:0]           in_start_day,
  input  logic signed [cdad_pkg::OFFSET_W-1:0] in_day_offset,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [cdad_pkg::YEAR_W-1:0]          out_result_year,
  output logic [cdad_pkg::MONTH_W-1:0]         out_result_month,
  output logic [cdad_pkg::DAY_W-1:0]           out_result_day,
  output logic [1:0]                           out_status
);
  import cdad_pkg::*;

  op_t    op;
  flags_t flags;

  cdad_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .flags    (flags),
    .in_ready (in_ready),
    .op       (op)
  );

  cdad_dp #(
    .YEAR_BITS   (YEAR_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .in_start_year    (in_start_year),
    .in_start_month   (in_start_month),
    .in_start_day     (in_start_day),
    .in_day_offset    (in_day_offset),
    .out_ready        (out_ready),
    .flags            (flags),
    .out_valid        (out_valid),
    .out_result_year  (out_result_year),
    .out_result_month (out_result_month),
    .out_result_day   (out_result_day),
    .out_status       (out_status)
  );

endmodule

>>> verif/tb.sv
// self-checking testbench for the gregorian date adder with a scoreboard class
`timescale 1ns / 1ps

module tb;
  import cdad_pkg::*;

  localparam int unsigned ERA_DAYS     = 146097;
  localparam int unsigned ERA_YEARS    = 400;
  localparam int unsigned YEAR_TOP     = 65535;
  localparam int          RANDOM_ITEMS = 1800;
  localparam int          STALL_LIMIT  = 200000;
  localparam int          TAIL_CYCLES  = 60;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    status_t            status;
  } date_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [YEAR_W-1:0]          in_start_year;
  logic [MONTH_W-1:0]         in_start_month;
  logic [DAY_W-1:0]           in_start_day;
  logic signed [OFFSET_W-1:0] in_day_offset;
  logic                       out_valid;
  logic                       out_ready;
  logic [YEAR_W-1:0]          out_result_year;
  logic [MONTH_W-1:0]         out_result_month;
  logic [DAY_W-1:0]           out_result_day;
  logic [1:0]                 out_status;

  bit gaps_on;
  int requests;
  int idle_cycles;

  calendar_date_add_days dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_start_year    (in_start_year),
    .in_start_month   (in_start_month),
    .in_start_day     (in_start_day),
    .in_day_offset    (in_day_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_year  (out_result_year),
    .out_result_month (out_result_month),
    .out_result_day   (out_result_day),
    .out_status       (out_status)
  );

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    bit leap;
    leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    case (m)
      2: return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      1, 3, 5, 7, 8, 10, 12: return 31;
      default: return 0;
    endcase
  endfunction

  function automatic date_result_t shift_date(logic [YEAR_W-1:0] y0, logic [MONTH_W-1:0] m0,
                                              logic [DAY_W-1:0] d0,
                                              logic signed [OFFSET_W-1:0] off);
    int unsigned y, m, d, rem, left;
    int o;
    date_result_t r;
    y = y0;
    m = m0;
    d = d0;
    o = off;
    rem = (o < 0) ? -o : o;
    r = '{'0, '0, '0, ST_BAD_DATE};
    if (y == 0 || m == 0 || m > 12 || d == 0 || d > month_days(y, m)) return r;
    r.status = ST_RANGE;
    if (o >= 0) begin
      while (rem >= ERA_DAYS) begin
        if (y > YEAR_TOP - ERA_YEARS) return r;
        y += ERA_YEARS;
        rem -= ERA_DAYS;
      end
      while (rem > 0) begin
        left = month_days(y, m) - d + 1;
        if (rem < left) begin
          d += rem;
          rem = 0;
        end else begin
          rem -= left;
          d = 1;
          m++;
          if (m > 12) begin
            if (y >= YEAR_TOP) return r;
            y++;
            m = 1;
          end
        end
      end
    end else begin
      while (rem >= ERA_DAYS) begin
        if (y <= ERA_YEARS) return r;
        y -= ERA_YEARS;
        rem -= ERA_DAYS;
      end
      while (rem > 0) begin
        if (d > rem) begin
          d -= rem;
          rem = 0;
        end else begin
          rem -= d;
          if (m > 1) begin
            m--;
          end else begin
            if (y <= 1) return r;
            y--;
            m = 12;
          end
          d = month_days(y, m);
        end
      end
    end
    r = '{y[YEAR_W-1:0], m[MONTH_W-1:0], d[DAY_W-1:0], ST_OK};
    return r;
  endfunction

  class date_scoreboard;
    date_result_t pending_dates[$];
    int errors;
    int checked;
    int n_ok;
    int n_bad;
    int n_range;

    function void note_request(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                               logic [DAY_W-1:0] d, logic signed [OFFSET_W-1:0] off);
      pending_dates.push_back(shift_date(y, m, d, off));
    endfunction

    function void cmp_field(string what, logic [YEAR_W-1:0] want, logic [YEAR_W-1:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
      end
    endfunction

    function void check_result(date_result_t got);
      date_result_t want;
      if (pending_dates.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none, got %0d-%0d-%0d st %0d",
                 $time, got.year, got.month, got.day, got.status);
        return;
      end
      want = pending_dates.pop_front();
      checked++;
      case (want.status)
        ST_OK:    n_ok++;
        ST_RANGE: n_range++;
        default:  n_bad++;
      endcase
      cmp_field("year", want.year, got.year);
      cmp_field("month", want.month, got.month);
      cmp_field("day", want.day, got.day);
      cmp_field("status", want.status, got.status);
    endfunction
  endclass

  date_scoreboard sb = new();

  always #5 clk = ~clk;

  // random backpressure on the result side
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= !(gaps_on && $urandom_range(99) < 14);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_result_year, out_result_month, out_result_day,
                        status_t'(out_status)});
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, sb.pending_dates.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                           input logic [DAY_W-1:0] d, input int off);
    while (gaps_on && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_start_year  <= y;
    in_start_month <= m;
    in_start_day   <= d;
    in_day_offset  <= off[OFFSET_W-1:0];
    do @(posedge clk); while (!in_ready);
    sb.note_request(y, m, d, off[OFFSET_W-1:0]);
    requests++;
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (sb.pending_dates.size() != 0) @(negedge clk);
  endtask

  task automatic pick_request(output logic [YEAR_W-1:0] y, output logic [MONTH_W-1:0] m,
                              output logic [DAY_W-1:0] d, output int off);
    int pick;
    int unsigned mag;
    int unsigned len;
    pick = $urandom_range(99);
    if (pick < 50) y = $urandom_range(3000, 1);
    else if (pick < 60) y = $urandom_range(5, 1);
    else if (pick < 70) y = $urandom_range(YEAR_TOP, YEAR_TOP - 5);
    else if (pick < 80) y = $urandom_range(655, 1) * 100;
    else y = $urandom_range(YEAR_TOP, 1);
    if ($urandom_range(99) < 12) begin
      // start dates that may be malformed
      if ($urandom_range(3) == 0) y = 0;
      else y = $urandom_range(YEAR_TOP, 0);
      m = $urandom_range(15, 0);
      d = $urandom_range(31, 0);
    end else begin
      m = $urandom_range(12, 1);
      len = month_days(y, m);
      pick = $urandom_range(99);
      if (pick < 25) d = len;
      else if (pick < 45) d = 1;
      else d = $urandom_range(len, 1);
    end
    pick = $urandom_range(99);
    if (pick < 55) mag = $urandom_range(120, 0);
    else if (pick < 94) mag = $urandom_range(4000, 0);
    else if (pick < 99) mag = $urandom_range(7, 1) * ERA_DAYS + $urandom_range(60, 0);
    else mag = $urandom_range(1048576, 0);
    off = $urandom_range(1) ? -int'(mag) : int'(mag);
  endtask

  initial begin
    logic [YEAR_W-1:0] y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0] d;
    int off;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_start_year = '0;
    in_start_month = '0;
    in_start_day = '0;
    in_day_offset = '0;
    gaps_on = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners
    send_date(2024, 2, 29, 0);
    send_date(2023, 2, 29, 1);
    send_date(1900, 2, 29, 0);
    send_date(2000, 2, 29, 365);
    send_date(0, 1, 1, 5);
    send_date(2020, 0, 10, 5);
    send_date(2020, 13, 10, 5);
    send_date(2020, 15, 31, 5);
    send_date(2020, 5, 0, 5);
    send_date(2021, 4, 31, 5);
    send_date(1, 1, 1, -1);
    send_date(65535, 12, 31, 1);
    send_date(65535, 12, 31, 0);
    send_date(400, 6, 15, -146097);
    send_date(401, 6, 15, -146097);
    send_date(65135, 1, 1, 146097);
    send_date(65136, 1, 1, 146097);
    send_date(2000, 1, 1, 1048575);
    send_date(65535, 12, 31, -1048576);
    send_date(2024, 12, 31, 1);
    send_date(2024, 1, 1, -1);
    send_date(2024, 3, 1, -1);
    send_date(2100, 2, 28, 1);
    hold_until_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gaps_on = !(i >= 700 && i < 1000);
      if (i == 1200) hold_until_drained();
      pick_request(y, m, d, off);
      send_date(y, m, d, off);
    end
    in_valid <= 1'b0;
    while (sb.pending_dates.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("%0d requests checked: %0d moved dates, %0d invalid start dates, %0d out of range",
             sb.checked, sb.n_ok, sb.n_bad, sb.n_range);
    $display("offsets spanned both directions, whole 400-year blocks and both year limits");
    if (sb.errors == 0 && sb.checked == requests) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
